### sv/dbd_pkg.sv
// Shared types and constants for the definite-length block deframer.
// Used by dbd_front, dbd_queue, dbd_back and definite_block_deframer; no dependencies.
package dbd_pkg;

    localparam int MAX_DIGITS  = 9;
    localparam int LEN_W       = 30;
    localparam int BYTE_W      = 8;
    localparam int DIGIT_W     = 4;
    localparam int ERR_W       = 3;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [BYTE_W-1:0] CHAR_HASH    = 8'd35;
    localparam logic [BYTE_W-1:0] CHAR_NEWLINE = 8'd10;
    localparam logic [BYTE_W-1:0] CHAR_ZERO    = 8'd48;
    localparam logic [BYTE_W-1:0] CHAR_NINE    = 8'd57;

    localparam logic [LEN_W-1:0] MAX_LENGTH_RESET = 30'd1048576;

    localparam logic [ERR_W-1:0] ERR_NONE  = 3'd0;
    localparam logic [ERR_W-1:0] ERR_LEAD  = 3'd1;
    localparam logic [ERR_W-1:0] ERR_INDEF = 3'd2;
    localparam logic [ERR_W-1:0] ERR_LEN   = 3'd3;
    localparam logic [ERR_W-1:0] ERR_OVF   = 3'd4;
    localparam logic [ERR_W-1:0] ERR_NONL  = 3'd5;

    typedef struct packed {
        logic [BYTE_W-1:0]  raw;
        logic               is_digit;
        logic [DIGIT_W-1:0] digit;
        logic               is_hash;
        logic               is_newline;
    } token_t;

endpackage

### sv/dbd_front.sv
// Front end of the deframer: accepts received bytes and classifies them into tokens.
// Depends on dbd_pkg; feeds dbd_queue.
module dbd_front
(
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [7:0]             rx_byte,
    input  logic                   queue_full,
    output logic                   push,
    output dbd_pkg::token_t        token
);

    logic [dbd_pkg::BYTE_W-1:0] offset;

    assign in_ready = !queue_full;
    assign push     = in_valid && !queue_full;
    assign offset   = rx_byte - dbd_pkg::CHAR_ZERO;

    always_comb
    begin
        token.raw        = rx_byte;
        token.is_digit   = (rx_byte >= dbd_pkg::CHAR_ZERO) && (rx_byte <= dbd_pkg::CHAR_NINE);
        token.digit      = offset[dbd_pkg::DIGIT_W-1:0];
        token.is_hash    = (rx_byte == dbd_pkg::CHAR_HASH);
        token.is_newline = (rx_byte == dbd_pkg::CHAR_NEWLINE);
    end

endmodule

### sv/dbd_queue.sv
// Short token queue between the front and back ends of the deframer.
// Depends on dbd_pkg.
module dbd_queue
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  dbd_pkg::token_t        push_token,
    output logic                   full,
    output logic                   head_valid,
    output dbd_pkg::token_t        head_token,
    input  logic                   pop
);

    dbd_pkg::token_t                 entry_reg [dbd_pkg::QUEUE_DEPTH];
    logic [dbd_pkg::QPTR_W-1:0]      wr_ptr_reg;
    logic [dbd_pkg::QPTR_W-1:0]      wr_ptr_next;
    logic [dbd_pkg::QPTR_W-1:0]      rd_ptr_reg;
    logic [dbd_pkg::QPTR_W-1:0]      rd_ptr_next;
    logic [dbd_pkg::QCNT_W-1:0]      count_reg;
    logic [dbd_pkg::QCNT_W-1:0]      count_next;
    logic                            do_pop;

    assign full       = (count_reg == dbd_pkg::QCNT_W'(dbd_pkg::QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_token = entry_reg[rd_ptr_reg];
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == dbd_pkg::QPTR_W'(dbd_pkg::QUEUE_DEPTH - 1))
                          ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == dbd_pkg::QPTR_W'(dbd_pkg::QUEUE_DEPTH - 1))
                          ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_token;
        end
    end

endmodule

### sv/dbd_back.sv
// Back end of the deframer: the block parser state machine and the result register.
// Depends on dbd_pkg; takes tokens from dbd_queue.
module dbd_back
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          head_valid,
    input  dbd_pkg::token_t               head_token,
    output logic                          pop,
    input  logic                          cfg_valid,
    input  logic [dbd_pkg::LEN_W-1:0]     cfg_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [7:0]                    data_byte,
    output logic                          data_valid,
    output logic                          last_data,
    output logic                          block_done,
    output logic [2:0]                    error_code,
    output logic [29:0]                   block_length
);

    localparam logic [2:0] PH_WAIT  = 3'd0;
    localparam logic [2:0] PH_COUNT = 3'd1;
    localparam logic [2:0] PH_LEN   = 3'd2;
    localparam logic [2:0] PH_DATA  = 3'd3;
    localparam logic [2:0] PH_NL    = 3'd4;

    logic [2:0]                     phase_reg;
    logic [2:0]                     phase_next;
    logic [dbd_pkg::DIGIT_W-1:0]    digits_left_reg;
    logic [dbd_pkg::DIGIT_W-1:0]    digits_left_next;
    logic [dbd_pkg::LEN_W-1:0]      length_accum_reg;
    logic [dbd_pkg::LEN_W-1:0]      length_accum_next;
    logic [dbd_pkg::LEN_W-1:0]      bytes_left_reg;
    logic [dbd_pkg::LEN_W-1:0]      bytes_left_next;
    logic [dbd_pkg::LEN_W-1:0]      max_length_reg;
    logic [dbd_pkg::LEN_W-1:0]      accum_times_ten;
    logic [dbd_pkg::LEN_W-1:0]      bytes_dec;
    logic [dbd_pkg::DIGIT_W-1:0]    digits_dec;

    logic                           out_valid_reg;
    logic [7:0]                     data_byte_reg;
    logic                           data_valid_reg;
    logic                           last_data_reg;
    logic                           block_done_reg;
    logic [2:0]                     error_code_reg;
    logic [29:0]                    block_length_reg;

    logic [7:0]                     data_byte_next;
    logic                           data_valid_next;
    logic                           last_data_next;
    logic                           block_done_next;
    logic [2:0]                     error_code_next;
    logic [29:0]                    block_length_next;

    assign pop = head_valid && (!out_valid_reg || out_ready);

    assign accum_times_ten = {length_accum_reg[dbd_pkg::LEN_W-4:0], 3'b000}
                           + {length_accum_reg[dbd_pkg::LEN_W-2:0], 1'b0}
                           + dbd_pkg::LEN_W'(head_token.digit);
    assign bytes_dec  = bytes_left_reg - 1'b1;
    assign digits_dec = digits_left_reg - 1'b1;

    always_comb
    begin
        phase_next        = phase_reg;
        digits_left_next  = digits_left_reg;
        length_accum_next = length_accum_reg;
        bytes_left_next   = bytes_left_reg;
        data_byte_next    = '0;
        data_valid_next   = 1'b0;
        last_data_next    = 1'b0;
        block_done_next   = 1'b0;
        error_code_next   = dbd_pkg::ERR_NONE;
        block_length_next = '0;
        unique case (phase_reg)
            PH_COUNT:
            begin
                phase_next = PH_WAIT;
                if (!head_token.is_digit)
                begin
                    error_code_next = dbd_pkg::ERR_LEAD;
                end
                else if (head_token.digit == '0)
                begin
                    error_code_next = dbd_pkg::ERR_INDEF;
                end
                else if (head_token.digit > dbd_pkg::DIGIT_W'(dbd_pkg::MAX_DIGITS))
                begin
                    error_code_next = dbd_pkg::ERR_LEAD;
                end
                else
                begin
                    digits_left_next  = head_token.digit;
                    length_accum_next = '0;
                    phase_next        = PH_LEN;
                end
            end
            PH_LEN:
            begin
                if (!head_token.is_digit)
                begin
                    error_code_next = dbd_pkg::ERR_LEN;
                    phase_next      = PH_WAIT;
                end
                else
                begin
                    length_accum_next = accum_times_ten;
                    digits_left_next  = digits_dec;
                    if (digits_dec == '0)
                    begin
                        if (accum_times_ten == '0)
                        begin
                            error_code_next = dbd_pkg::ERR_LEN;
                            phase_next      = PH_WAIT;
                        end
                        else if (accum_times_ten > max_length_reg)
                        begin
                            error_code_next   = dbd_pkg::ERR_OVF;
                            block_length_next = accum_times_ten;
                            phase_next        = PH_WAIT;
                        end
                        else
                        begin
                            block_length_next = accum_times_ten;
                            bytes_left_next   = accum_times_ten;
                            phase_next        = PH_DATA;
                        end
                    end
                end
            end
            PH_DATA:
            begin
                data_byte_next    = head_token.raw;
                data_valid_next   = 1'b1;
                block_length_next = length_accum_reg;
                bytes_left_next   = bytes_dec;
                if (bytes_dec == '0)
                begin
                    last_data_next = 1'b1;
                    phase_next     = PH_NL;
                end
            end
            PH_NL:
            begin
                block_length_next = length_accum_reg;
                phase_next        = PH_WAIT;
                if (head_token.is_newline)
                begin
                    block_done_next = 1'b1;
                end
                else
                begin
                    error_code_next = dbd_pkg::ERR_NONL;
                end
            end
            default:
            begin
                if (head_token.is_hash)
                begin
                    phase_next = PH_COUNT;
                end
                else
                begin
                    error_code_next = dbd_pkg::ERR_LEAD;
                    phase_next      = PH_WAIT;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_WAIT;
            digits_left_reg  <= '0;
            length_accum_reg <= '0;
            bytes_left_reg   <= '0;
            max_length_reg   <= dbd_pkg::MAX_LENGTH_RESET;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                max_length_reg <= cfg_data;
            end
            if (pop)
            begin
                phase_reg        <= phase_next;
                digits_left_reg  <= digits_left_next;
                length_accum_reg <= length_accum_next;
                bytes_left_reg   <= bytes_left_next;
                out_valid_reg    <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            data_byte_reg    <= data_byte_next;
            data_valid_reg   <= data_valid_next;
            last_data_reg    <= last_data_next;
            block_done_reg   <= block_done_next;
            error_code_reg   <= error_code_next;
            block_length_reg <= block_length_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign data_byte    = data_byte_reg;
    assign data_valid   = data_valid_reg;
    assign last_data    = last_data_reg;
    assign block_done   = block_done_reg;
    assign error_code   = error_code_reg;
    assign block_length = block_length_reg;

endmodule

### sv/definite_block_deframer.sv
// Top level of the definite-length block deframer.
// Depends on dbd_pkg, dbd_front, dbd_queue and dbd_back.
//
// Each request on the input channel (in_valid/in_ready, rx_byte) carries one
// received byte, and for every byte exactly one request leaves on the output
// channel (out_valid/out_ready) with the payload byte, the last-byte and done
// flags, an error code and the announced block length.
// The max_length register is written through cfg_valid/cfg_ready/cfg_data;
// cfg_ready is always high, and writes are meant for an idle block.
// A byte accepted on the input is classified combinationally and written into a
// four-entry token queue; the parser takes it from the queue head and its result
// is registered for the output channel.
// Throughput is one byte per clock while the receiver keeps out_ready high, with
// each parser step doing one 30-bit multiply-by-ten add and length compare.
// When the receiver stalls, the result register holds and the queue absorbs
// up to four more bytes before in_ready falls.
// Reset clears the parser to waiting for '#', empties the queue and sets
// max_length to 1048576.
module definite_block_deframer
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  data_byte,
    output logic        data_valid,
    output logic        last_data,
    output logic        block_done,
    output logic [2:0]  error_code,
    output logic [29:0] block_length,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [29:0] cfg_data
);

    dbd_pkg::token_t push_token;
    dbd_pkg::token_t head_token;
    logic            push;
    logic            queue_full;
    logic            head_valid;
    logic            pop;

    assign cfg_ready = 1'b1;

    dbd_front u_front
    (
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .rx_byte    (rx_byte),
        .queue_full (queue_full),
        .push       (push),
        .token      (push_token)
    );

    dbd_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_token (push_token),
        .full       (queue_full),
        .head_valid (head_valid),
        .head_token (head_token),
        .pop        (pop)
    );

    dbd_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (head_valid),
        .head_token   (head_token),
        .pop          (pop),
        .cfg_valid    (cfg_valid),
        .cfg_data     (cfg_data),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .data_byte    (data_byte),
        .data_valid   (data_valid),
        .last_data    (last_data),
        .block_done   (block_done),
        .error_code   (error_code),
        .block_length (block_length)
    );

endmodule
